// File: sv/scoc_pkg.sv
// Shared constants for the sphere/cone overlap test core.
// Holds the unit-vector format, normalizer widths and configuration register codes.
// No dependencies.
package scoc_pkg;

    // Unit axis vector format: signed Q1.30 held in 32 bits.
    localparam int UNIT_W     = 32;
    localparam int UNIT_SHIFT = 30;

    // Axis magnitudes are scaled so the largest lies in [2^23, 2^24).
    localparam int NORM_W = 24;

    // Half-angle sine: unsigned Q1.16, one is 65536.
    localparam int              SINE_W    = 17;
    localparam int              SINE_FRAC = 16;
    localparam logic [SINE_W-1:0] SINE_ONE = 17'h10000;

    // Configuration register indexes.
    localparam int             REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_APEX_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_APEX_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_APEX_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Z = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SINE   = 3'd6;

endpackage

// File: sv/sphere_cone_overlap_test_core.sv
// Top level of the sphere/cone overlap test: configuration registers, axis
// normalizer, geometry pipeline, bounding-sphere square root and final compare.
// Depends on scoc_pkg, scoc_axis_norm, scoc_geom_pipe and scoc_isqrt_pipe.
//
//   Channel   Signals                                   Beat accepted when
//   -------   ---------------------------------------   ---------------------
//   command   start, busy, centre_*, extent_*           start high, busy low
//   result    done, overlaps, in_front                  every cycle done is high
//   config    cfg_write, cfg_index, cfg_data            cfg_write high
//
// One beat is accepted per cycle while busy is low; every command beat yields exactly
// one result beat through the geometry stages, one-bit-per-stage square root and tail.
// The receiver cannot stall, so the pipeline never holds and valid bits simply
// march with the data. Writing any axis register restarts the axis normalizer,
// which holds busy high through shift, square, a 25-step root and a 31-step
// divide. Reset clears all valid bits and loads the reset axis directly.
module sphere_cone_overlap_test_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_WIDTH-1:0]        centre_x,
    input  logic signed [COORD_WIDTH-1:0]        centre_y,
    input  logic signed [COORD_WIDTH-1:0]        centre_z,
    input  logic [COORD_WIDTH-2:0]               extent_x,
    input  logic [COORD_WIDTH-2:0]               extent_y,
    input  logic [COORD_WIDTH-2:0]               extent_z,
    output logic                                 done,
    output logic                                 overlaps,
    output logic                                 in_front,
    input  logic                                 cfg_write,
    input  logic [scoc_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [((COORD_WIDTH > scoc_pkg::SINE_W) ? COORD_WIDTH
                                                    : scoc_pkg::SINE_W)-1:0] cfg_data
);

    localparam int PW     = COORD_WIDTH + 5;
    localparam int DSQ_W  = 2 * COORD_WIDTH + 2;
    localparam int ESQ_W  = 2 * COORD_WIDTH;
    localparam int RTW    = (ESQ_W + 1) / 2;
    localparam int SIDE_W = 1 + PW + DSQ_W;
    localparam int RR_W   = PW + 1;
    localparam int CMP_W  = 2 * RR_W;
    localparam logic signed [COORD_WIDTH-1:0] AXIS_X_RESET = COORD_WIDTH'(1) << FRAC_BITS;

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0]     apex_reg [3];
    logic signed [COORD_WIDTH-1:0]     axis_reg [3];
    logic [scoc_pkg::SINE_W-1:0]       sine_reg;
    logic [scoc_pkg::SINE_W-1:0]       sine_clamped;
    logic                              axis_kick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apex_reg[0] <= '0;
            apex_reg[1] <= '0;
            apex_reg[2] <= '0;
            axis_reg[0] <= AXIS_X_RESET;
            axis_reg[1] <= '0;
            axis_reg[2] <= '0;
            sine_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                scoc_pkg::REG_APEX_X: apex_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                scoc_pkg::REG_APEX_Y: apex_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                scoc_pkg::REG_APEX_Z: apex_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                scoc_pkg::REG_AXIS_X: axis_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                scoc_pkg::REG_AXIS_Y: axis_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                scoc_pkg::REG_AXIS_Z: axis_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                scoc_pkg::REG_SINE:   sine_reg    <= cfg_data[scoc_pkg::SINE_W-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Any axis write retriggers normalization, which reads the new value next cycle.
    always_comb
    begin
        axis_kick = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                scoc_pkg::REG_AXIS_X,
                scoc_pkg::REG_AXIS_Y,
                scoc_pkg::REG_AXIS_Z: axis_kick = 1'b1;
                default:              axis_kick = 1'b0;
            endcase
        end
    end

    // Sines above one behave as one.
    assign sine_clamped = (sine_reg > scoc_pkg::SINE_ONE) ? scoc_pkg::SINE_ONE : sine_reg;

    logic signed [scoc_pkg::UNIT_W-1:0] unit [3];
    logic                               norm_busy;

    scoc_axis_norm #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .kick  (axis_kick),
        .axis  (axis_reg),
        .busy  (norm_busy),
        .unit  (unit)
    );

    assign busy = norm_busy;

    logic                           accept;
    logic signed [COORD_WIDTH-1:0]  centre [3];
    logic [COORD_WIDTH-2:0]         extent [3];

    assign accept    = start && !norm_busy;
    assign centre[0] = centre_x;
    assign centre[1] = centre_y;
    assign centre[2] = centre_z;
    assign extent[0] = extent_x;
    assign extent[1] = extent_y;
    assign extent[2] = extent_z;

    logic              g_vld;
    logic              g_front;
    logic [PW-1:0]     g_cone_r;
    logic [DSQ_W-1:0]  g_perp_sq;
    logic [ESQ_W-1:0]  g_ext_sq;

    scoc_geom_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .centre    (centre),
        .extent    (extent),
        .apex      (apex_reg),
        .unit      (unit),
        .sine      (sine_clamped),
        .out_valid (g_vld),
        .front     (g_front),
        .cone_r    (g_cone_r),
        .perp_sq   (g_perp_sq),
        .ext_sq    (g_ext_sq)
    );

    // The bounding-sphere radius is the floor root of the summed squared extents.
    logic              s_vld;
    logic [RTW-1:0]    s_root;
    logic [SIDE_W-1:0] s_side;

    scoc_isqrt_pipe #(
        .IN_W   (ESQ_W),
        .SIDE_W (SIDE_W)
    ) u_sphere_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_vld),
        .radicand  (g_ext_sq),
        .side_in   ({g_front, g_cone_r, g_perp_sq}),
        .out_valid (s_vld),
        .root      (s_root),
        .side_out  (s_side)
    );

    // Tail stages. The floor root of the perpendicular square is below the
    // combined radius exactly when the square itself is below that radius squared,
    // so no second root is taken.
    logic              f_vld_reg;
    logic              f_front_reg;
    logic [RR_W-1:0]   f_rad_reg;
    logic [DSQ_W-1:0]  f_perp_sq_reg;
    logic              h_vld_reg;
    logic              h_front_reg;
    logic [CMP_W-1:0]  h_rad_sq_reg;
    logic [DSQ_W-1:0]  h_perp_sq_reg;
    logic              done_reg;
    logic              overlaps_reg;
    logic              in_front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            f_vld_reg <= s_vld;
            h_vld_reg <= f_vld_reg;
            done_reg  <= h_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_front_reg   <= s_side[SIDE_W-1];
        f_rad_reg     <= RR_W'(s_root) + RR_W'(s_side[DSQ_W +: PW]);
        f_perp_sq_reg <= s_side[DSQ_W-1:0];

        h_front_reg   <= f_front_reg;
        h_rad_sq_reg  <= CMP_W'(f_rad_reg) * CMP_W'(f_rad_reg);
        h_perp_sq_reg <= f_perp_sq_reg;

        in_front_reg  <= h_front_reg;
        overlaps_reg  <= h_front_reg && (CMP_W'(h_perp_sq_reg) < h_rad_sq_reg);
    end

    assign done     = done_reg;
    assign overlaps = overlaps_reg;
    assign in_front = in_front_reg;

endmodule

// File: sv/scoc_axis_norm.sv
// Sequential normalizer that turns the configured cone axis into a Q1.30 unit vector.
// Uses an iterative square root and three bit-serial dividers.
// Depends on scoc_pkg.
module scoc_axis_norm #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    kick,
    input  logic signed [COORD_WIDTH-1:0]           axis [3],
    output logic                                    busy,
    output logic signed [scoc_pkg::UNIT_W-1:0]      unit [3]
);

    localparam int NW     = scoc_pkg::NORM_W;
    localparam int L2_W   = 2 * NW + 2;
    localparam int ROOT_W = NW + 1;
    localparam int QW     = scoc_pkg::UNIT_SHIFT + 1;
    localparam int RW     = NW + 2;
    localparam int CNT_W  = $clog2(QW);
    localparam int MSB_W  = $clog2(COORD_WIDTH);
    localparam logic [L2_W-1:0] BIT_TOP = L2_W'(1) << (2 * (ROOT_W - 1));

    typedef enum logic [2:0] {ST_IDLE, ST_SHIFT, ST_SQUARE, ST_ROOT, ST_DIVIDE} state_t;

    state_t                          state_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [NW-1:0]                   b_reg [3];
    logic                            neg_reg [3];
    logic [L2_W-1:0]                 rem_reg;
    logic [L2_W-1:0]                 res_reg;
    logic [L2_W-1:0]                 bit_reg;
    logic [RW-1:0]                   r_reg [3];
    logic [QW-1:0]                   q_reg [3];
    logic signed [scoc_pkg::UNIT_W-1:0] unit_reg [3];

    logic [COORD_WIDTH-1:0]          mag [3];
    logic [COORD_WIDTH-1:0]          mx;
    logic [MSB_W-1:0]                msb;
    logic [COORD_WIDTH+NW-1:0]       mag_ext [3];
    logic [NW-1:0]                   b_calc [3];
    logic [L2_W-1:0]                 l2_sum;
    logic [L2_W-1:0]                 trial;
    logic [ROOT_W-1:0]               len;
    logic                            ge [3];
    logic [RW-1:0]                   r_sub [3];
    logic [RW-1:0]                   r_next [3];
    logic [QW-1:0]                   q_next [3];

    always_comb
    begin
        mx  = '0;
        msb = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = axis[i][COORD_WIDTH-1] ? COORD_WIDTH'(-axis[i]) : COORD_WIDTH'(axis[i]);
            if (mag[i] > mx)
            begin
                mx = mag[i];
            end
        end
        for (int i = 0; i < COORD_WIDTH; i++)
        begin
            if (mx[i])
            begin
                msb = MSB_W'(i);
            end
        end
        l2_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag_ext[i] = (COORD_WIDTH + NW)'(mag[i]);
            if (int'(msb) >= NW - 1)
            begin
                b_calc[i] = NW'(mag_ext[i] >> (int'(msb) - (NW - 1)));
            end
            else
            begin
                b_calc[i] = NW'(mag_ext[i] << ((NW - 1) - int'(msb)));
            end
            l2_sum = l2_sum + L2_W'(b_reg[i] * b_reg[i]);
        end
        trial = res_reg + bit_reg;
        len   = res_reg[ROOT_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            ge[i]     = r_reg[i] >= RW'(len);
            r_sub[i]  = ge[i] ? (r_reg[i] - RW'(len)) : r_reg[i];
            r_next[i] = {r_sub[i][RW-2:0], 1'b0};
            q_next[i] = {q_reg[i][QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            res_reg   <= '0;
            bit_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                b_reg[i]   <= '0;
                neg_reg[i] <= 1'b0;
                r_reg[i]   <= '0;
                q_reg[i]   <= '0;
            end
            // Reset axis (1, 0, 0) normalizes to exactly one along x.
            unit_reg[0] <= scoc_pkg::UNIT_W'(1) << scoc_pkg::UNIT_SHIFT;
            unit_reg[1] <= '0;
            unit_reg[2] <= '0;
        end
        else if (kick)
        begin
            state_reg <= ST_SHIFT;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SHIFT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        b_reg[i]   <= b_calc[i];
                        neg_reg[i] <= axis[i][COORD_WIDTH-1];
                    end
                    if (mx == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            unit_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    rem_reg   <= l2_sum;
                    res_reg   <= '0;
                    bit_reg   <= BIT_TOP;
                    cnt_reg   <= CNT_W'(ROOT_W - 1);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            r_reg[i] <= RW'(b_reg[i]);
                            q_reg[i] <= '0;
                        end
                        cnt_reg   <= CNT_W'(QW - 1);
                        state_reg <= ST_DIVIDE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DIVIDE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        r_reg[i] <= r_next[i];
                        q_reg[i] <= q_next[i];
                    end
                    if (cnt_reg == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            unit_reg[i] <= neg_reg[i] ? -scoc_pkg::UNIT_W'(q_next[i])
                                                      : scoc_pkg::UNIT_W'(q_next[i]);
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign unit = unit_reg;

endmodule

// File: sv/scoc_geom_pipe.sv
// Front pipeline stages: offset from apex, axis projection, squared lengths,
// cone radius and squared perpendicular distance.
// Depends on scoc_pkg.
module scoc_geom_pipe #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [COORD_WIDTH-1:0]           centre [3],
    input  logic [COORD_WIDTH-2:0]                  extent [3],
    input  logic signed [COORD_WIDTH-1:0]           apex [3],
    input  logic signed [scoc_pkg::UNIT_W-1:0]      unit [3],
    input  logic [scoc_pkg::SINE_W-1:0]             sine,
    output logic                                    out_valid,
    output logic                                    front,
    output logic [COORD_WIDTH+4:0]                  cone_r,
    output logic [2*COORD_WIDTH+1:0]                perp_sq,
    output logic [2*COORD_WIDTH-1:0]                ext_sq
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int UW    = scoc_pkg::UNIT_W;
    localparam int PRW   = UW + DW;
    localparam int TW    = PRW + 2;
    localparam int PW    = TW - scoc_pkg::UNIT_SHIFT;
    localparam int DSQ_W = 2 * COORD_WIDTH + 2;
    localparam int ESQ_W = 2 * COORD_WIDTH;
    localparam int PSQ_W = 2 * PW;
    localparam int PS_W  = PW + scoc_pkg::SINE_W;

    // Stage A: offsets from apex.
    logic                    a_vld_reg;
    logic signed [DW-1:0]    d_reg [3];
    logic [COORD_WIDTH-2:0]  e_reg [3];
    // Stage B: products.
    logic                    b_vld_reg;
    logic signed [PRW-1:0]   prod_reg [3];
    logic [2*DW-1:0]         dsq_reg [3];
    logic [ESQ_W-3:0]        esq_reg [3];
    // Stage C: sums.
    logic                    c_vld_reg;
    logic signed [TW-1:0]    t_reg;
    logic [DSQ_W-1:0]        dsum_reg;
    logic [ESQ_W-1:0]        esum_c_reg;
    // Stage D: projection squared and cone radius product.
    logic                    d_vld_reg;
    logic                    d_front_reg;
    logic [PSQ_W-1:0]        psq_reg;
    logic [PS_W-1:0]         ps_reg;
    logic [DSQ_W-1:0]        dsum_d_reg;
    logic [ESQ_W-1:0]        esum_d_reg;
    // Stage E: outputs.
    logic                    e_vld_reg;
    logic                    e_front_reg;
    logic [PW-1:0]           cone_r_reg;
    logic [DSQ_W-1:0]        perp_sq_reg;
    logic [ESQ_W-1:0]        ext_sq_reg;

    logic [DW-1:0]           d_mag [3];
    logic [PW-1:0]           proj;
    logic [PSQ_W-1:0]        dsum_ext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_mag[i] = d_reg[i][DW-1] ? DW'(-d_reg[i]) : DW'(d_reg[i]);
        end
        proj     = t_reg[TW-1:scoc_pkg::UNIT_SHIFT];
        dsum_ext = PSQ_W'(dsum_d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i]    <= DW'(centre[i]) - DW'(apex[i]);
            e_reg[i]    <= extent[i];
            prod_reg[i] <= PRW'(unit[i]) * PRW'(d_reg[i]);
            dsq_reg[i]  <= (2 * DW)'(d_mag[i]) * (2 * DW)'(d_mag[i]);
            esq_reg[i]  <= (ESQ_W - 2)'(e_reg[i]) * (ESQ_W - 2)'(e_reg[i]);
        end
        t_reg       <= TW'(prod_reg[0]) + TW'(prod_reg[1]) + TW'(prod_reg[2]);
        dsum_reg    <= DSQ_W'(dsq_reg[0]) + DSQ_W'(dsq_reg[1]) + DSQ_W'(dsq_reg[2]);
        esum_c_reg  <= ESQ_W'(esq_reg[0]) + ESQ_W'(esq_reg[1]) + ESQ_W'(esq_reg[2]);

        d_front_reg <= !t_reg[TW-1] && (t_reg != '0);
        psq_reg     <= PSQ_W'(proj) * PSQ_W'(proj);
        ps_reg      <= PS_W'(proj) * PS_W'(sine);
        dsum_d_reg  <= dsum_reg;
        esum_d_reg  <= esum_c_reg;

        // A negative perpendicular square is clamped to zero.
        e_front_reg <= d_front_reg;
        cone_r_reg  <= ps_reg[scoc_pkg::SINE_FRAC +: PW];
        perp_sq_reg <= (psq_reg <= dsum_ext) ? DSQ_W'(dsum_ext - psq_reg) : '0;
        ext_sq_reg  <= esum_d_reg;
    end

    assign out_valid = e_vld_reg;
    assign front     = e_front_reg;
    assign cone_r    = cone_r_reg;
    assign perp_sq   = perp_sq_reg;
    assign ext_sq    = ext_sq_reg;

endmodule

// File: sv/scoc_isqrt_pipe.sv
// Pipelined floor square root, one root bit per register stage.
// Carries a side payload alongside the radicand. Has no dependencies.
// Uses no package items.
module scoc_isqrt_pipe #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [IN_W-1:0]         radicand,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    out_valid,
    output logic [(IN_W+1)/2-1:0]   root,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int RW = (IN_W + 1) / 2;
    localparam int AW = 2 * RW;

    logic [AW-1:0]     rem_reg  [RW];
    logic [AW-1:0]     res_reg  [RW];
    logic [SIDE_W-1:0] side_reg [RW];
    logic              vld_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam logic [AW-1:0] BIT = AW'(1) << (2 * (RW - 1 - k));
        logic [AW-1:0]     rem_in;
        logic [AW-1:0]     res_in;
        logic [SIDE_W-1:0] side_st;
        logic              vld_in;
        logic [AW-1:0]     trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = AW'(radicand);
            assign res_in  = '0;
            assign side_st = side_in;
            assign vld_in  = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_st = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_st;
            if (rem_in >= trial)
            begin
                rem_reg[k] <= rem_in - trial;
                res_reg[k] <= (res_in >> 1) + BIT;
            end
            else
            begin
                rem_reg[k] <= rem_in;
                res_reg[k] <= res_in >> 1;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = res_reg[RW-1][RW-1:0];
    assign side_out  = side_reg[RW-1];

endmodule
